### src/tll_pkg.sv
// Shared types and constants for the level-order leaf listing block.
`timescale 1ns / 1ps
`default_nettype none
package tll_pkg;

	// Width of a child index as carried by an input word and by the queue
	localparam int unsigned IDX_W = 4;

	// Leaves delivered per tree at most, and the width of the leaf counter
	localparam int unsigned RESULT_LIMIT = 16;
	localparam int unsigned LEAF_CNT_W   = 5;

	// Result status codes
	typedef enum logic [1:0] {
		ST_LEAF      = 2'd0,
		ST_NO_ROOT   = 2'd1,
		ST_BAD_CHILD = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// One node as held in the link table
	typedef struct packed {
		logic             has_left;
		logic [IDX_W-1:0] left;
		logic             has_right;
		logic [IDX_W-1:0] right;
	} node_t;

	// Summary handed from the loader to the walker when a tree is complete
	typedef struct packed {
		logic start;
		logic overflow;
		logic bad_child;
	} tree_sum_t;

endpackage : tll_pkg
`default_nettype wire

### src/tll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tll_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : tll_ram
`default_nettype wire

### src/tll_loader.sv
// Node loader: stores links, counts nodes, keeps reference marks and range check.
`timescale 1ns / 1ps
`default_nettype none
module tll_loader import tll_pkg::*; #(
	parameter int unsigned MAX_NODES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [IDX_W-1:0]                 left_index,
	input  wire logic                             has_left,
	input  wire logic [IDX_W-1:0]                 right_index,
	input  wire logic                             has_right,
	input  wire logic                             last,
	// link table write port
	output logic                                  tbl_we,
	output logic [$clog2(MAX_NODES)-1:0]          tbl_waddr,
	output node_t                                 tbl_wdata,
	// towards the walker
	output tree_sum_t                             sum,
	output logic [$clog2(MAX_NODES+1)-1:0]        count,
	output logic [MAX_NODES-1:0]                  marks,
	input  wire logic                             tree_done
);

	localparam int unsigned IW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	logic                 busy_q;
	logic                 start_q;
	logic [CW-1:0]        count_q;
	logic                 overflow_q;
	logic [MAX_NODES-1:0] marks_q;
	logic [MAX_NODES-1:0] marks_d;
	logic                 child_any_q;
	logic [IDX_W-1:0]     child_max_q;
	logic                 child_any_d;
	logic [IDX_W-1:0]     child_max_d;
	logic                 accept;
	logic                 store;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign store    = accept && (32'(count_q) < MAX_NODES);

	// Reference marks set by this word's children
	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			marks_d[i] = marks_q[i]
				| (store && has_left  && (32'(left_index)  == i))
				| (store && has_right && (32'(right_index) == i));
		end
	end

	// Highest child index named so far
	always_comb begin
		child_any_d = child_any_q;
		child_max_d = child_max_q;
		if (store && has_left) begin
			if (!child_any_d || (left_index > child_max_d)) begin
				child_max_d = left_index;
			end
			child_any_d = 1'b1;
		end
		if (store && has_right) begin
			if (!child_any_d || (right_index > child_max_d)) begin
				child_max_d = right_index;
			end
			child_any_d = 1'b1;
		end
	end

	// Load state, cleared when the walker has delivered the tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			marks_q     <= '0;
			child_any_q <= 1'b0;
			child_max_q <= '0;
		end else begin
			start_q <= accept && last;
			if (tree_done) begin
				busy_q      <= 1'b0;
				count_q     <= '0;
				overflow_q  <= 1'b0;
				marks_q     <= '0;
				child_any_q <= 1'b0;
				child_max_q <= '0;
			end else if (accept) begin
				if (last) begin
					busy_q <= 1'b1;
				end
				if (store) begin
					count_q <= count_q + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
				marks_q     <= marks_d;
				child_any_q <= child_any_d;
				child_max_q <= child_max_d;
			end
		end
	end

	// Table write
	assign tbl_we              = store;
	assign tbl_waddr           = count_q[IW-1:0];
	assign tbl_wdata.has_left  = has_left;
	assign tbl_wdata.left      = left_index;
	assign tbl_wdata.has_right = has_right;
	assign tbl_wdata.right     = right_index;

	// Summary for the walker: start is a pulse, the rest stable while busy
	assign sum.start     = start_q;
	assign sum.overflow  = overflow_q;
	assign sum.bad_child = child_any_q && (32'(child_max_q) >= 32'(count_q));
	assign count         = count_q;
	assign marks         = marks_q;

	// Checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_NODES)
		else $error("node count beyond table depth");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (32'(count_q) == MAX_NODES))
		else $error("overflow flagged with table not full");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> busy_q)
		else $error("tree start without load closed");

endmodule : tll_loader
`default_nettype wire

### src/tll_walker.sv
// Walker: root scan, breadth-first walk through the queue RAM, result register.
`timescale 1ns / 1ps
`default_nettype none
module tll_walker import tll_pkg::*; #(
	parameter int unsigned MAX_NODES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// from the loader
	input  wire tree_sum_t                        sum,
	input  wire logic [$clog2(MAX_NODES+1)-1:0]   count,
	input  wire logic [MAX_NODES-1:0]             marks,
	output logic                                  tree_done,
	// link table read port
	output logic                                  tbl_re,
	output logic [$clog2(MAX_NODES)-1:0]          tbl_raddr,
	input  wire node_t                            tbl_rdata,
	// queue RAM
	output logic                                  q_we,
	output logic [$clog2(MAX_NODES)-1:0]          q_waddr,
	output logic [IDX_W-1:0]                      q_wdata,
	output logic                                  q_re,
	output logic [$clog2(MAX_NODES)-1:0]          q_raddr,
	input  wire logic [IDX_W-1:0]                 q_rdata,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [IDX_W-1:0]                      leaf_index,
	output logic [1:0]                            status,
	output logic                                  final_res
);

	localparam int unsigned IW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(MAX_NODES + 1);
	localparam logic [IW-1:0] LAST_PTR = IW'(MAX_NODES - 1);

	typedef enum logic [6:0] {
		W_IDLE  = 7'b0000001,
		W_SCAN  = 7'b0000010,
		W_POP   = 7'b0000100,
		W_NODE  = 7'b0001000,
		W_KIDS  = 7'b0010000,
		W_RIGHT = 7'b0100000,
		W_END   = 7'b1000000
	} walk_state_t;

	walk_state_t           state_q, state_d;
	logic [IW-1:0]         scan_q, scan_d;
	logic [IW-1:0]         head_q, head_d;
	logic [IW-1:0]         tail_q, tail_d;
	logic [CW-1:0]         fill_q, fill_d;
	logic [CW-1:0]         pops_q, pops_d;
	logic [LEAF_CNT_W-1:0] leafs_q, leafs_d;
	logic                  pend_valid_q, pend_valid_d;
	logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
	logic [IDX_W-1:0]      node_q, node_d;
	status_t               end_status_q, end_status_d;

	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_leaf_q;
	status_t               out_status_q;
	logic                  out_final_q;

	logic                  slot_free;
	logic                  ld_out;
	logic [IDX_W-1:0]      ld_leaf;
	status_t               ld_status;
	logic                  ld_final;
	logic                  is_leaf;
	logic                  take_leaf;

	assign slot_free = !out_valid_q || !out_stall;
	assign is_leaf   = !tbl_rdata.has_left && !tbl_rdata.has_right;
	assign take_leaf = is_leaf && (32'(leafs_q) < RESULT_LIMIT);

	// Sequencer
	always_comb begin
		state_d      = state_q;
		scan_d       = scan_q;
		head_d       = head_q;
		tail_d       = tail_q;
		fill_d       = fill_q;
		pops_d       = pops_q;
		leafs_d      = leafs_q;
		pend_valid_d = pend_valid_q;
		pend_idx_d   = pend_idx_q;
		node_d       = node_q;
		end_status_d = end_status_q;
		q_we         = 1'b0;
		q_waddr      = tail_q;
		q_wdata      = '0;
		q_re         = 1'b0;
		q_raddr      = head_q;
		tbl_re       = 1'b0;
		tbl_raddr    = IW'(q_rdata);
		ld_out       = 1'b0;
		ld_leaf      = '0;
		ld_status    = ST_LEAF;
		ld_final     = 1'b0;
		tree_done    = 1'b0;
		unique case (state_q)
			W_IDLE: begin
				head_d       = '0;
				tail_d       = '0;
				fill_d       = '0;
				pops_d       = '0;
				leafs_d      = '0;
				pend_valid_d = 1'b0;
				scan_d       = '0;
				end_status_d = ST_NO_ROOT;
				if (sum.start) begin
					if (sum.overflow) begin
						end_status_d = ST_OVERFLOW;
						state_d      = W_END;
					end else if (sum.bad_child) begin
						end_status_d = ST_BAD_CHILD;
						state_d      = W_END;
					end else begin
						state_d = W_SCAN;
					end
				end
			end
			// one mark per cycle; the first clear one is the root
			W_SCAN: begin
				if (!marks[scan_q]) begin
					q_we    = 1'b1;
					q_wdata = IDX_W'(scan_q);
					tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + IW'(1);
					fill_d  = fill_q + CW'(1);
					state_d = W_POP;
				end else if ((32'(scan_q) + 32'd1) >= 32'(count)) begin
					state_d = W_END;
				end else begin
					scan_d = scan_q + IW'(1);
				end
			end
			W_POP: begin
				q_re    = 1'b1;
				head_d  = (head_q == LAST_PTR) ? '0 : head_q + IW'(1);
				fill_d  = fill_q - CW'(1);
				pops_d  = pops_q + CW'(1);
				state_d = W_NODE;
			end
			// queue word is out; fetch its links unless out of range
			W_NODE: begin
				node_d = q_rdata;
				if (32'(q_rdata) >= 32'(count)) begin
					state_d = ((fill_q != '0) && (pops_q < count)) ? W_POP : W_END;
				end else begin
					tbl_re  = 1'b1;
					state_d = W_KIDS;
				end
			end
			// links are out; push left, hold a new leaf and hand over any held one
			W_KIDS: begin
				if (!(take_leaf && pend_valid_q && !slot_free)) begin
					if (tbl_rdata.has_left && (32'(fill_q) < MAX_NODES)) begin
						q_we    = 1'b1;
						q_wdata = tbl_rdata.left;
						tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + IW'(1);
						fill_d  = fill_q + CW'(1);
					end
					if (take_leaf) begin
						if (pend_valid_q) begin
							ld_out  = 1'b1;
							ld_leaf = pend_idx_q;
						end
						pend_valid_d = 1'b1;
						pend_idx_d   = node_q;
						leafs_d      = leafs_q + LEAF_CNT_W'(1);
					end
					state_d = W_RIGHT;
				end
			end
			W_RIGHT: begin
				if (tbl_rdata.has_right && (32'(fill_q) < MAX_NODES)) begin
					q_we    = 1'b1;
					q_wdata = tbl_rdata.right;
					tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + IW'(1);
					fill_d  = fill_q + CW'(1);
				end
				state_d = ((fill_d != '0) && (pops_q < count)) ? W_POP : W_END;
			end
			// closing word: held leaf, or the status of the tree
			W_END: begin
				if (slot_free) begin
					ld_out    = 1'b1;
					ld_final  = 1'b1;
					ld_leaf   = pend_valid_q ? pend_idx_q : '0;
					ld_status = pend_valid_q ? ST_LEAF : end_status_q;
					tree_done = 1'b1;
					state_d   = W_IDLE;
				end
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= W_IDLE;
			scan_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			pops_q       <= '0;
			leafs_q      <= '0;
			pend_valid_q <= 1'b0;
			end_status_q <= ST_NO_ROOT;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			scan_q       <= scan_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			fill_q       <= fill_d;
			pops_q       <= pops_d;
			leafs_q      <= leafs_d;
			pend_valid_q <= pend_valid_d;
			end_status_q <= end_status_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pend_idx_q <= pend_idx_d;
		node_q     <= node_d;
		if (ld_out) begin
			out_leaf_q   <= ld_leaf;
			out_status_q <= ld_status;
			out_final_q  <= ld_final;
		end
	end

	assign out_valid  = out_valid_q;
	assign leaf_index = out_leaf_q;
	assign status     = out_status_q;
	assign final_res  = out_final_q;

	// Checks
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != W_IDLE) |-> (32'(fill_q) <= MAX_NODES))
		else $error("queue fill beyond depth");
	a_pops_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == W_NODE) |-> (pops_q <= count))
		else $error("more pops than nodes");
	a_kids_from_node: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == W_KIDS) |-> $past(state_q == W_NODE))
		else $error("link data used without a table read");
	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		tree_done |=> (out_valid_q && out_final_q))
		else $error("tree closed without a final word");
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (leafs_q != '0))
		else $error("held leaf not counted");

endmodule : tll_walker
`default_nettype wire

### src/tree_leaves_level_order.sv
// Top level of the level-order leaf listing block.
`timescale 1ns / 1ps
`default_nettype none
// Loads a binary tree one node per input word (node i is the i-th word since the
// last tree) and, after the word marked last, lists the leaf indices in level
// order, the last one with final_res set; a bad tree gives a single status word
// instead. Words are taken without a stall up to the word marked last; then the
// block closes the load (in_stall high) until the tree ends, scans the reference
// marks for the root at one node per cycle, then walks the tree, each visited
// node in turn: a queue RAM read, a link table RAM read, then the left and the
// right child slot in separate steps, as pushes share the single queue write
// port. A closing word ends the tree, after which the next tree may load. Reference
// marks sit in flip-flops and are cleared in the cycle the tree ends. A result
// word waiting on out_stall holds the walk only when a further word must go out.
module tree_leaves_level_order import tll_pkg::*; #(
	parameter int unsigned MAX_NODES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// input channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [IDX_W-1:0] left_index,
	input  wire logic             has_left,
	input  wire logic [IDX_W-1:0] right_index,
	input  wire logic             has_right,
	input  wire logic             last,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [IDX_W-1:0]      leaf_index,
	output logic [1:0]            status,
	output logic                  final_res
);

	localparam int unsigned IW = $clog2(MAX_NODES);
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	logic                 tbl_we;
	logic [IW-1:0]        tbl_waddr;
	node_t                tbl_wdata;
	logic                 tbl_re;
	logic [IW-1:0]        tbl_raddr;
	node_t                tbl_rdata;
	logic                 q_we;
	logic [IW-1:0]        q_waddr;
	logic [IDX_W-1:0]     q_wdata;
	logic                 q_re;
	logic [IW-1:0]        q_raddr;
	logic [IDX_W-1:0]     q_rdata;
	tree_sum_t            sum;
	logic [CW-1:0]        count;
	logic [MAX_NODES-1:0] marks;
	logic                 tree_done;

	// Node loader
	tll_loader #(
		.MAX_NODES (MAX_NODES)
	) u_loader (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_index  (left_index),
		.has_left    (has_left),
		.right_index (right_index),
		.has_right   (has_right),
		.last        (last),
		.tbl_we      (tbl_we),
		.tbl_waddr   (tbl_waddr),
		.tbl_wdata   (tbl_wdata),
		.sum         (sum),
		.count       (count),
		.marks       (marks),
		.tree_done   (tree_done)
	);

	// Link table
	tll_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (MAX_NODES)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// Circular queue store
	tll_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_NODES)
	) u_q_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Walker and result register
	tll_walker #(
		.MAX_NODES (MAX_NODES)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum        (sum),
		.count      (count),
		.marks      (marks),
		.tree_done  (tree_done),
		.tbl_re     (tbl_re),
		.tbl_raddr  (tbl_raddr),
		.tbl_rdata  (tbl_rdata),
		.q_we       (q_we),
		.q_waddr    (q_waddr),
		.q_wdata    (q_wdata),
		.q_re       (q_re),
		.q_raddr    (q_raddr),
		.q_rdata    (q_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.leaf_index (leaf_index),
		.status     (status),
		.final_res  (final_res)
	);

endmodule : tree_leaves_level_order
`default_nettype wire

### dv/tb_tree_leaves_level_order.sv
// Testbench for tree_leaves_level_order: random and directed trees checked against a predictor.
`timescale 1ns / 1ps

localparam int NODE_CAP = 16;

// One expected result word
typedef struct {
	logic [3:0]        leaf;
	tll_pkg::status_t  st;
	logic              fin;
} leaf_word_t;

// Tracks the tree being loaded and predicts the leaf listing for it
class leaf_scoreboard;
	tll_pkg::node_t links[NODE_CAP];
	bit             referenced[NODE_CAP];
	int             held;
	bit             overflowed;
	leaf_word_t     due[$];
	int             mismatches;

	function int pending();
		return due.size();
	endfunction

	// Push a single status word
	function void expect_status(tll_pkg::status_t st);
		leaf_word_t w;
		w.leaf = '0;
		w.st   = st;
		w.fin  = 1'b1;
		due.push_back(w);
	endfunction

	// Validate the loaded tree and walk it breadth first
	function void list_leaves();
		logic [3:0] ring[NODE_CAP];
		leaf_word_t found_leaves[$];
		leaf_word_t w;
		int head, fill, pops, root;
		logic [3:0] nd;
		tll_pkg::node_t lk;
		if (overflowed) begin
			expect_status(tll_pkg::ST_OVERFLOW);
			return;
		end
		for (int i = 0; i < held; i++) begin
			if ((links[i].has_left && links[i].left >= held) ||
			    (links[i].has_right && links[i].right >= held)) begin
				expect_status(tll_pkg::ST_BAD_CHILD);
				return;
			end
		end
		root = -1;
		for (int i = 0; i < held; i++) begin
			if (!referenced[i]) begin
				root = i;
				break;
			end
		end
		if (root < 0) begin
			expect_status(tll_pkg::ST_NO_ROOT);
			return;
		end
		ring[0] = 4'(root);
		head = 0;
		fill = 1;
		pops = 0;
		while (fill > 0 && pops < held) begin
			nd = ring[head];
			head = (head + 1) % NODE_CAP;
			fill--;
			pops++;
			lk = links[nd];
			// pushes onto a full ring are dropped
			if (lk.has_left && fill < NODE_CAP) begin
				ring[(head + fill) % NODE_CAP] = lk.left;
				fill++;
			end
			if (lk.has_right && fill < NODE_CAP) begin
				ring[(head + fill) % NODE_CAP] = lk.right;
				fill++;
			end
			if (!lk.has_left && !lk.has_right &&
			    found_leaves.size() < tll_pkg::RESULT_LIMIT) begin
				w.leaf = nd;
				w.st   = tll_pkg::ST_LEAF;
				w.fin  = 1'b0;
				found_leaves.push_back(w);
			end
		end
		if (found_leaves.size() == 0) begin
			expect_status(tll_pkg::ST_NO_ROOT);
			return;
		end
		found_leaves[found_leaves.size() - 1].fin = 1'b1;
		foreach (found_leaves[i])
			due.push_back(found_leaves[i]);
	endfunction

	// Accepted input word
	function void note_node(tll_pkg::node_t nd, logic lst);
		if (held < NODE_CAP) begin
			links[held] = nd;
			if (nd.has_left)
				referenced[nd.left] = 1'b1;
			if (nd.has_right)
				referenced[nd.right] = 1'b1;
			held++;
		end else begin
			overflowed = 1'b1;
		end
		if (lst) begin
			list_leaves();
			foreach (referenced[i])
				referenced[i] = 1'b0;
			held = 0;
			overflowed = 1'b0;
		end
	endfunction

	// Accepted result word
	function void check_word(logic [3:0] leaf, logic [1:0] st, logic fin);
		leaf_word_t e;
		if (due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected word leaf=%0d status=%0d final=%0b",
					$realtime, leaf, st, fin);
			return;
		end
		e = due.pop_front();
		if (e.leaf !== leaf || e.st !== st || e.fin !== fin) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: mismatch exp leaf=%0d status=%0d final=%0b, ",
					"got leaf=%0d status=%0d final=%0b"},
					$realtime, e.leaf, e.st, e.fin, leaf, st, fin);
		end
	endfunction
endclass

module tb_tree_leaves_level_order;
	import tll_pkg::*;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	logic [IDX_W-1:0] left_index  = '0;
	logic             has_left    = 1'b0;
	logic [IDX_W-1:0] right_index = '0;
	logic             has_right   = 1'b0;
	logic             last        = 1'b0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	logic [IDX_W-1:0] leaf_index;
	logic [1:0]       status;
	logic             final_res;

	int send_idle_pct = 37;
	int recv_idle_pct = 57;
	int sent_words    = 0;

	leaf_scoreboard sb = new();

	tree_leaves_level_order #(
		.MAX_NODES(NODE_CAP)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.left_index (left_index),
		.has_left   (has_left),
		.right_index(right_index),
		.has_right  (has_right),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.leaf_index (leaf_index),
		.status     (status),
		.final_res  (final_res)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_node({has_left, left_index, has_right, right_index}, last);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(leaf_index, status, final_res);
	end

	function automatic node_t mk(logic hl, logic [3:0] l, logic hr, logic [3:0] r);
		return {hl, l, hr, r};
	endfunction

	// Drive one node word and wait for it to be taken
	task automatic send_word(input node_t nd, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		has_left    <= nd.has_left;
		left_index  <= nd.left;
		has_right   <= nd.has_right;
		right_index <= nd.right;
		last        <= lst;
		do @(posedge clk); while (in_stall);
		sent_words++;
	endtask

	// Proper tree of n nodes with shuffled labels, optionally with one bad link,
	// followed by extra random words (these overflow the table when n is full)
	task automatic send_tree(input int n, input bit corrupt, input int extra);
		node_t lk[NODE_CAP];
		int    perm[NODE_CAP];
		int    j, t, k;
		node_t junk;
		for (k = 0; k < NODE_CAP; k++) begin
			perm[k] = k;
			lk[k] = node_t'($urandom);
			lk[k].has_left = 1'b0;
			lk[k].has_right = 1'b0;
		end
		for (k = n - 1; k > 0; k--) begin
			j = $urandom_range(k);
			t = perm[k];
			perm[k] = perm[j];
			perm[j] = t;
		end
		// hang each node off a free slot of an earlier one
		for (k = 1; k < n; k++) begin
			do j = perm[$urandom_range(k - 1)]; while (lk[j].has_left && lk[j].has_right);
			if (!lk[j].has_left && (lk[j].has_right || $urandom_range(1))) begin
				lk[j].has_left = 1'b1;
				lk[j].left = 4'(perm[k]);
			end else begin
				lk[j].has_right = 1'b1;
				lk[j].right = 4'(perm[k]);
			end
		end
		if (corrupt && n > 0) begin
			j = $urandom_range(n - 1);
			if ($urandom_range(1)) begin
				lk[j].has_left = 1'b1;
				lk[j].left = 4'($urandom);
			end else begin
				lk[j].has_right = 1'b1;
				lk[j].right = 4'($urandom);
			end
		end
		for (k = 0; k < n; k++)
			send_word(lk[k], (k == n - 1) && (extra == 0));
		for (k = 0; k < extra; k++) begin
			junk = node_t'($urandom);
			send_word(junk, k == extra - 1);
		end
	endtask

	initial begin
		int directed_words, kind, done_random;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single node, index fields at their top but unused
		send_word(mk(1'b0, 4'd15, 1'b0, 4'd15), 1'b1);
		// self loop: every node referenced
		send_word(mk(1'b1, 4'd0, 1'b0, 4'd0), 1'b1);
		// child beyond the node count
		send_word(mk(1'b0, 4'd0, 1'b1, 4'd15), 1'b1);
		// root is the highest node
		send_word(mk(1'b0, 4'd0, 1'b0, 4'd0), 1'b0);
		send_word(mk(1'b0, 4'd0, 1'b0, 4'd0), 1'b0);
		send_word(mk(1'b1, 4'd0, 1'b1, 4'd1), 1'b1);
		// same child twice
		send_word(mk(1'b1, 4'd1, 1'b1, 4'd1), 1'b0);
		send_word(mk(1'b0, 4'd3, 1'b0, 4'd12), 1'b1);
		// cycle under the root, walk finds no leaf
		send_word(mk(1'b1, 4'd1, 1'b0, 4'd0), 1'b0);
		send_word(mk(1'b0, 4'd0, 1'b1, 4'd2), 1'b0);
		send_word(mk(1'b1, 4'd1, 1'b0, 4'd0), 1'b1);
		// one node too many
		send_tree(NODE_CAP, 1'b0, 1);
		directed_words = sent_words;

		// random trees over three idling regimes
		while (sent_words < directed_words + 470) begin
			done_random = sent_words - directed_words;
			if (done_random < 157) begin
				send_idle_pct = 37;
				recv_idle_pct = 57;
			end else if (done_random < 314) begin
				send_idle_pct = 57;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = $urandom_range(99);
			if (kind < 68)
				send_tree($urandom_range(1, NODE_CAP), 1'b0, 0);
			else if (kind < 80)
				send_tree($urandom_range(1, NODE_CAP), 1'b1, 0);
			else if (kind < 92)
				send_tree(0, 1'b0, $urandom_range(1, 6));
			else
				send_tree(NODE_CAP, 1'($urandom_range(1)), $urandom_range(1, 4));
		end
		in_valid <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
